### design/region_access_checker_macros.svh
// Assertion macros for the region access checker.
`ifndef REGION_ACCESS_CHECKER_MACROS_SVH
`define REGION_ACCESS_CHECKER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define RAC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define RAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/rac_pkg.sv
// Shared types and codes for the region access checker.
`timescale 1ns / 1ps
package rac_pkg;

  localparam int ADDR_W = 64;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_SEAL  = 2'd1;
  localparam logic [1:0] REQ_CHECK = 2'd2;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_INVALID     = 4'd1;
  localparam logic [3:0] ST_OVERLAP     = 4'd2;
  localparam logic [3:0] ST_FULL        = 4'd3;
  localparam logic [3:0] ST_SEALED      = 4'd4;
  localparam logic [3:0] ST_MISALIGNED  = 4'd5;
  localparam logic [3:0] ST_CODE_WRITE  = 4'd6;
  localparam logic [3:0] ST_READ_FAULT  = 4'd7;
  localparam logic [3:0] ST_WRITE_FAULT = 4'd8;

  localparam int RIGHT_READ  = 0;
  localparam int RIGHT_WRITE = 1;
  localparam int RIGHT_CODE  = 2;

  // One table entry; lim is the exclusive end, base + size.
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] lim;
    logic [2:0]        rights;
  } region_t;

  typedef struct packed {
    logic hit;
    logic overlap;
    logic reach;
  } cmp_res_t;

endpackage

### design/rac_table.sv
// Region table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module rac_table
  import rac_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int IDX_W = 3
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  region_t          wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output region_t          rd_data
);

  region_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

### design/rac_cmp.sv
// Shared compare unit: tests one table entry against the cursor and limit.
`timescale 1ns / 1ps
module rac_cmp
  import rac_pkg::*;
(
  input  logic [ADDR_W-1:0] cur,
  input  logic [ADDR_W-1:0] lim,
  input  region_t           ent,
  output cmp_res_t          res
);

  logic below_lim;

  assign below_lim   = cur < ent.lim;
  assign res.hit     = (cur >= ent.base) && below_lim;
  assign res.overlap = below_lim && (ent.base < lim);
  assign res.reach   = ent.lim >= lim;

endmodule

### design/region_access_checker.sv
// Region access checker top level: request sequencer, table and compare unit.
`timescale 1ns / 1ps
`include "region_access_checker_macros.svh"
// Seal, unknown requests, rejected adds, misaligned checks and zero-length or
// wrapping checks answer in the cycle after the transfer. An add otherwise walks
// the table one entry per cycle through the single compare unit and answers
// once an overlap is found or the walk ends; on an empty table no entry is read.
// A check walks the table the same way from entry 0 to find the region holding
// the current byte, then restarts from entry 0 at the end of that region; a
// byte held by no region ends the walk with a fault. The table memory read
// port sets the one-entry-per-cycle pace. A new request is taken only while
// idle, with the output register empty or unloading in the same cycle.
module region_access_checker
  import rac_pkg::*;
#(
  parameter int NUM_REGIONS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [ADDR_W-1:0] in_length,
  input  logic [2:0]        in_rights,
  input  logic              in_is_write,
  input  logic [6:0]        in_alignment,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        out_status
);

  localparam int IDX_W = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam int CNT_W = $clog2(NUM_REGIONS + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic              state_r, state_nxt;
  logic              op_add_r, op_add_nxt;
  logic [ADDR_W-1:0] at_r, at_nxt;
  logic [ADDR_W-1:0] lim_r, lim_nxt;
  logic [2:0]        rights_r, rights_nxt;
  logic              wr_r, wr_nxt;
  logic              bad_r, bad_nxt;
  logic [CNT_W-1:0]  scan_r, scan_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              locked_r, locked_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [3:0]        out_status_r, out_status_nxt;

  logic              accept;
  logic [ADDR_W:0]   sum;
  logic [6:0]        al_m1;
  logic              align_bad;
  logic              add_bad;
  logic              len_bad;
  logic [3:0]        in_fault;
  logic [3:0]        fault;
  logic              rd_issue;
  logic              ent_bad;
  logic              tbl_wr;
  region_t           wr_data;
  region_t           rd_data;
  cmp_res_t          cmp;

  assign in_ready   = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept     = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

  assign sum       = {1'b0, in_address} + {1'b0, in_length};
  assign al_m1     = in_alignment - 7'd1;
  assign align_bad = (in_alignment == 7'd0) || ((in_alignment & al_m1) != 7'd0) ||
                     ((in_address[6:0] & al_m1) != 7'd0);
  assign len_bad   = (in_length == '0) || sum[ADDR_W];
  assign add_bad   = locked_r || len_bad || (in_rights == 3'd0) ||
                     (in_rights[RIGHT_WRITE] && !in_rights[RIGHT_READ]) ||
                     (in_rights[RIGHT_CODE] && in_rights[RIGHT_WRITE]);
  assign in_fault  = in_is_write ? ST_WRITE_FAULT : ST_READ_FAULT;
  assign fault     = wr_r ? ST_WRITE_FAULT : ST_READ_FAULT;

  assign rd_issue = (state_r == S_SCAN) && (scan_r < count_r);
  assign ent_bad  = wr_r ? !rd_data.rights[RIGHT_WRITE] : !rd_data.rights[RIGHT_READ];

  assign wr_data.base   = at_r;
  assign wr_data.lim    = lim_r;
  assign wr_data.rights = rights_r;

  rac_table #(
    .DEPTH (NUM_REGIONS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_idx  (count_r[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_issue),
    .rd_idx  (scan_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  rac_cmp u_cmp (
    .cur (at_r),
    .lim (lim_r),
    .ent (rd_data),
    .res (cmp)
  );

  always_comb begin
    state_nxt      = state_r;
    op_add_nxt     = op_add_r;
    at_nxt         = at_r;
    lim_nxt        = lim_r;
    rights_nxt     = rights_r;
    wr_nxt         = wr_r;
    bad_nxt        = bad_r;
    scan_nxt       = rd_issue ? scan_r + CNT_W'(1) : scan_r;
    rd_pend_nxt    = rd_issue;
    count_nxt      = count_r;
    locked_nxt     = locked_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    tbl_wr         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        rd_pend_nxt = 1'b0;
        if (accept) begin
          at_nxt     = in_address;
          lim_nxt    = sum[ADDR_W-1:0];
          rights_nxt = in_rights;
          wr_nxt     = in_is_write;
          bad_nxt    = 1'b0;
          scan_nxt   = '0;
          case (in_req_type)
            REQ_ADD: begin
              if (add_bad) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_INVALID;
              end else begin
                op_add_nxt = 1'b1;
                state_nxt  = S_SCAN;
              end
            end
            REQ_SEAL: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = locked_r ? ST_SEALED : ST_OK;
              locked_nxt     = 1'b1;
            end
            REQ_CHECK: begin
              if (align_bad) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_MISALIGNED;
              end else if (len_bad) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = in_fault;
              end else begin
                op_add_nxt = 1'b0;
                state_nxt  = S_SCAN;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_INVALID;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rd_pend_r) begin
          if (op_add_r) begin
            if (cmp.overlap) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OVERLAP;
              state_nxt      = S_IDLE;
              rd_pend_nxt    = 1'b0;
            end
          end else if (cmp.hit) begin
            rd_pend_nxt = 1'b0;
            if (wr_r && rd_data.rights[RIGHT_CODE]) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_CODE_WRITE;
              state_nxt      = S_IDLE;
            end else if (!wr_r && ent_bad) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = fault;
              state_nxt      = S_IDLE;
            end else if (cmp.reach) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = (bad_r || ent_bad) ? fault : ST_OK;
              state_nxt      = S_IDLE;
            end else begin
              // step past this region and rescan from the first entry
              bad_nxt  = bad_r || ent_bad;
              at_nxt   = rd_data.lim;
              scan_nxt = '0;
            end
          end
        end else if (!rd_issue) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (!op_add_r) begin
            out_status_nxt = fault;
          end else if (count_r == CNT_W'(NUM_REGIONS)) begin
            out_status_nxt = ST_FULL;
          end else begin
            tbl_wr         = 1'b1;
            count_nxt      = count_r + CNT_W'(1);
            out_status_nxt = ST_OK;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_pend_r   <= 1'b0;
      count_r     <= '0;
      locked_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      count_r     <= count_nxt;
      locked_r    <= locked_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_add_r     <= op_add_nxt;
    at_r         <= at_nxt;
    lim_r        <= lim_nxt;
    rights_r     <= rights_nxt;
    wr_r         <= wr_nxt;
    bad_r        <= bad_nxt;
    scan_r       <= scan_nxt;
    out_status_r <= out_status_nxt;
  end

  `RAC_ASSERT_IMPL(a_count_max, 1'b1, count_r <= CNT_W'(NUM_REGIONS), "region count overflow")
  `RAC_ASSERT_IMPL(a_out_idle_busy, state_r == S_SCAN, !out_valid_r, "result held during scan")
  `RAC_ASSERT_NEXT(a_lock_sticky, locked_r, locked_r, "seal flag cleared")
  `RAC_ASSERT_IMPL(a_pend_scan, rd_pend_r, state_r == S_SCAN, "table read pending outside scan")
  `RAC_ASSERT_IMPL(a_scan_bound, state_r == S_SCAN, scan_r <= count_r, "scan index past count")

endmodule

### test/tb_region_access_checker.sv
// Self-checking testbench for region_access_checker: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_region_access_checker;
  import rac_pkg::*;

  localparam int NUM_REGIONS = 8;
  localparam int NUM_DIRECTED = 28;
  localparam int ITEMS_PER_PHASE = 430;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 100;
  localparam int EXP_DEPTH = 4096;
  localparam logic [1:0] REQ_UNDEF = 2'd3;
  localparam logic [63:0] TOP_ADDR = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] HIGH_BASE = 64'hFFFF_FFFF_FFFF_F000;
  localparam int unsigned SEND_IDLE [4] = '{0, 64, 0, 28};
  localparam int unsigned RECV_STALL [4] = '{0, 0, 64, 28};

  typedef struct packed {
    logic [1:0]  req;
    logic [63:0] addr;
    logic [63:0] len;
    logic [2:0]  rights;
    logic        wr;
    logic [6:0]  align;
  } req_t;

  typedef struct packed {
    req_t       item;
    logic       known;
    logic [3:0] status;
  } dir_row_t;

  // Rows with known = 0 are checked against the predictor.
  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    '{'{REQ_CHECK, 64'h1000, 64'd1, 3'd0, 1'b0, 7'd1}, 1'b1, ST_READ_FAULT},
    '{'{REQ_CHECK, 64'h1000, 64'd1, 3'd0, 1'b1, 7'd0}, 1'b1, ST_MISALIGNED},
    '{'{REQ_CHECK, 64'h1000, 64'd1, 3'd0, 1'b0, 7'd3}, 1'b1, ST_MISALIGNED},
    '{'{REQ_CHECK, 64'h1004, 64'd4, 3'd0, 1'b0, 7'd8}, 1'b1, ST_MISALIGNED},
    '{'{REQ_ADD, 64'h1000, 64'd0, 3'd3, 1'b0, 7'd0}, 1'b1, ST_INVALID},
    '{'{REQ_ADD, TOP_ADDR, 64'd1, 3'd3, 1'b0, 7'd0}, 1'b1, ST_INVALID},
    '{'{REQ_ADD, 64'h1000, 64'h10, 3'd0, 1'b0, 7'd0}, 1'b1, ST_INVALID},
    '{'{REQ_ADD, 64'h1000, 64'h10, 3'd2, 1'b0, 7'd0}, 1'b1, ST_INVALID},
    '{'{REQ_ADD, 64'h1000, 64'h10, 3'd6, 1'b0, 7'd0}, 1'b1, ST_INVALID},
    '{'{REQ_ADD, 64'h1000, 64'h1000, 3'd3, 1'b0, 7'd0}, 1'b1, ST_OK},
    '{'{REQ_ADD, 64'h1800, 64'h100, 3'd1, 1'b0, 7'd0}, 1'b1, ST_OVERLAP},
    '{'{REQ_ADD, 64'h2000, 64'h1000, 3'd1, 1'b0, 7'd0}, 1'b1, ST_OK},
    '{'{REQ_ADD, 64'h3000, 64'h1000, 3'd5, 1'b0, 7'd0}, 1'b1, ST_OK},
    '{'{REQ_ADD, HIGH_BASE, 64'hFFF, 3'd3, 1'b0, 7'd0}, 1'b1, ST_OK},
    '{'{REQ_ADD, 64'h0, 64'd1, 3'd4, 1'b0, 7'd0}, 1'b1, ST_OK},
    '{'{REQ_ADD, 64'h5000, 64'h100, 3'd3, 1'b0, 7'd0}, 1'b1, ST_OK},
    '{'{REQ_ADD, 64'h5100, 64'h100, 3'd3, 1'b0, 7'd0}, 1'b1, ST_OK},
    '{'{REQ_ADD, 64'h5200, 64'h100, 3'd1, 1'b0, 7'd0}, 1'b1, ST_OK},
    '{'{REQ_ADD, 64'h9000, 64'h10, 3'd1, 1'b0, 7'd0}, 1'b1, ST_FULL},
    '{'{REQ_CHECK, 64'h1000, 64'h3000, 3'd0, 1'b0, 7'd64}, 1'b0, ST_OK},
    '{'{REQ_CHECK, 64'h1000, 64'h1800, 3'd0, 1'b1, 7'd8}, 1'b0, ST_OK},
    '{'{REQ_CHECK, 64'h2800, 64'h1000, 3'd0, 1'b1, 7'd8}, 1'b0, ST_OK},
    '{'{REQ_CHECK, 64'h5000, 64'h200, 3'd0, 1'b1, 7'd64}, 1'b0, ST_OK},
    '{'{REQ_CHECK, HIGH_BASE, 64'hFFF, 3'd0, 1'b0, 7'd64}, 1'b0, ST_OK},
    '{'{REQ_CHECK, TOP_ADDR, 64'd1, 3'd0, 1'b0, 7'd1}, 1'b1, ST_READ_FAULT},
    '{'{REQ_CHECK, 64'h5000, 64'd0, 3'd0, 1'b1, 7'd1}, 1'b1, ST_WRITE_FAULT},
    '{'{REQ_CHECK, 64'h0, 64'd1, 3'd0, 1'b0, 7'd1}, 1'b0, ST_OK},
    '{'{REQ_UNDEF, 64'h0, 64'd0, 3'd0, 1'b0, 7'd0}, 1'b1, ST_INVALID}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = REQ_ADD;
  logic [63:0] in_address = '0;
  logic [63:0] in_length = '0;
  logic [2:0]  in_rights = '0;
  logic        in_is_write = 1'b0;
  logic [6:0]  in_alignment = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_status;

  // Predictor copy of the region table.
  logic [63:0] tbl_base [NUM_REGIONS];
  logic [63:0] tbl_size [NUM_REGIONS];
  logic [2:0]  tbl_rights [NUM_REGIONS];
  int          tbl_count = 0;
  logic        tbl_sealed = 1'b0;

  // Expected results in transfer order; written by the driver, read by the checker.
  logic [3:0]  exp_fifo [EXP_DEPTH];
  int          exp_wr = 0;
  int          exp_rd = 0;
  logic [3:0]  exp_status;
  int          fail_cnt = 0;
  int          idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  region_access_checker #(.NUM_REGIONS(NUM_REGIONS)) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_address  (in_address),
    .in_length   (in_length),
    .in_rights   (in_rights),
    .in_is_write (in_is_write),
    .in_alignment(in_alignment),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] rand_u64();
    return {$urandom, $urandom};
  endfunction

  function automatic int find_owner(input logic [63:0] a);
    for (int i = 0; i < tbl_count; i++)
      if (a >= tbl_base[i] && a - tbl_base[i] < tbl_size[i]) return i;
    return -1;
  endfunction

  // Expected status of one request; updates the table copy like the block does.
  function automatic logic [3:0] predict_status(input req_t it);
    logic [63:0] at;
    logic [63:0] left;
    logic [63:0] room;
    logic [3:0]  fault;
    int          r;
    int          steps;
    int          need;
    case (it.req)
      REQ_ADD: begin
        if (tbl_sealed || it.len == 64'd0 || it.len > ~it.addr || it.rights == 3'd0 ||
            (it.rights[RIGHT_WRITE] && !it.rights[RIGHT_READ]) ||
            (it.rights[RIGHT_CODE] && it.rights[RIGHT_WRITE]))
          return ST_INVALID;
        for (int i = 0; i < tbl_count; i++)
          if (it.addr < tbl_base[i] + tbl_size[i] && tbl_base[i] < it.addr + it.len)
            return ST_OVERLAP;
        if (tbl_count >= NUM_REGIONS) return ST_FULL;
        tbl_base[tbl_count] = it.addr;
        tbl_size[tbl_count] = it.len;
        tbl_rights[tbl_count] = it.rights;
        tbl_count++;
        return ST_OK;
      end
      REQ_SEAL: begin
        if (tbl_sealed) return ST_SEALED;
        tbl_sealed = 1'b1;
        return ST_OK;
      end
      REQ_CHECK: begin
        need = it.wr ? RIGHT_WRITE : RIGHT_READ;
        fault = it.wr ? ST_WRITE_FAULT : ST_READ_FAULT;
        if (it.align == 7'd0 || (it.align & (it.align - 7'd1)) != 7'd0 ||
            (it.addr & (64'(it.align) - 64'd1)) != 64'd0)
          return ST_MISALIGNED;
        if (it.len == 64'd0 || it.len > ~it.addr) return fault;
        // a write may not touch code anywhere along the contiguous run
        if (it.wr) begin
          at = it.addr;
          left = it.len;
          for (steps = 0; left != 0 && steps <= NUM_REGIONS; steps++) begin
            r = find_owner(at);
            if (r < 0) break;
            if (tbl_rights[r][RIGHT_CODE]) return ST_CODE_WRITE;
            room = tbl_size[r] - (at - tbl_base[r]);
            if (room > left) room = left;
            at += room;
            left -= room;
          end
        end
        at = it.addr;
        left = it.len;
        for (steps = 0; left != 0; steps++) begin
          if (steps > NUM_REGIONS) return fault;
          r = find_owner(at);
          if (r < 0 || !tbl_rights[r][need] || (it.wr && tbl_rights[r][RIGHT_CODE]))
            return fault;
          room = tbl_size[r] - (at - tbl_base[r]);
          if (room > left) room = left;
          at += room;
          left -= room;
        end
        return ST_OK;
      end
      default: return ST_INVALID;
    endcase
  endfunction

  function automatic req_t noise_item(input logic [1:0] req);
    req_t it;
    it.req = req;
    it.addr = rand_u64();
    it.len = ($urandom_range(1) == 0) ? rand_u64() : 64'($urandom_range(0, 'h2000));
    it.rights = 3'($urandom_range(7));
    it.wr = 1'($urandom_range(1));
    it.align = 7'($urandom_range(127));
    return it;
  endfunction

  // Check aimed at the start, end or interior of a stored region; mostly well-formed.
  function automatic req_t aimed_check();
    req_t        it;
    int          r;
    logic [63:0] off;
    logic [6:0]  al;
    it = noise_item(REQ_CHECK);
    r = $urandom_range(tbl_count - 1);
    case ($urandom_range(3))
      0: off = 64'd0;
      1: off = tbl_size[r] - 64'd1;
      default: off = rand_u64() % tbl_size[r];
    endcase
    al = 7'd1 << $urandom_range(6);
    it.addr = tbl_base[r] + off;
    if ($urandom_range(9) != 0) it.addr = it.addr & ~(64'(al) - 64'd1);
    it.align = al;
    case ($urandom_range(4))
      0: it.len = 64'd1;
      1: it.len = tbl_size[r] - off;
      2: it.len = tbl_size[r] - off + 64'($urandom_range(1, 'h300));
      3: it.len = 64'($urandom_range(1, 'h3800));
      default: it.len = ($urandom_range(7) == 0) ? rand_u64() : 64'($urandom_range(0, 'h40));
    endcase
    return it;
  endfunction

  function automatic req_t random_add();
    req_t it;
    int   r;
    it = noise_item(REQ_ADD);
    r = $urandom_range(tbl_count - 1);
    case ($urandom_range(3))
      0: it.addr = tbl_base[r] + tbl_size[r];
      1: it.addr = tbl_base[r] + 64'($urandom_range(0, 'h100));
      2: it.addr = tbl_base[r] - 64'($urandom_range(1, 'h100));
      default: ;
    endcase
    if ($urandom_range(3) != 0) it.len = 64'($urandom_range(0, 'h1000));
    return it;
  endfunction

  task automatic send_req(input req_t it, input logic known, input logic [3:0] typed);
    logic [3:0] pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= it.req;
    in_address <= it.addr;
    in_length <= it.len;
    in_rights <= it.rights;
    in_is_write <= it.wr;
    in_alignment <= it.align;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = predict_status(it);
    exp_fifo[exp_wr % EXP_DEPTH] = known ? typed : pred;
    exp_wr++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (exp_wr == exp_rd) begin
          if (fail_cnt < 10) $display("unexpected result transfer: status %0d", out_status);
          fail_cnt++;
        end else begin
          exp_status = exp_fifo[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (out_status !== exp_status) begin
            if (fail_cnt < 10)
              $display("status mismatch: expected %0d, got %0d", exp_status, out_status);
            fail_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    req_t it;
    int   pick;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_req(DIRECTED[i].item, DIRECTED[i].known, DIRECTED[i].status);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = SEND_IDLE[ph];
      recv_stall_pct = RECV_STALL[ph];
      if (ph == 3) begin
        it = noise_item(REQ_SEAL);
        send_req(it, 1'b1, ST_OK);
        send_req(it, 1'b1, ST_SEALED);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < 55) it = aimed_check();
        else if (pick < 70) it = noise_item(REQ_CHECK);
        else if (pick < 88) it = random_add();
        else if (pick < 94) it = noise_item(REQ_UNDEF);
        else if (ph == 3) it = noise_item(REQ_SEAL);
        else it = aimed_check();
        send_req(it, 1'b0, ST_OK);
      end
    end
    in_valid <= 1'b0;

    while (exp_wr != exp_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && exp_wr == exp_rd) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/rac_pkg.sv
design/rac_table.sv
design/rac_cmp.sv
design/region_access_checker.sv
test/tb_region_access_checker.sv
